// ===== hw/rtl/spim_pkg.sv =====
// Shared types and constants for the sorted point table with tolerance merge.
// Used by spim_cell, spim_pick and sorted_point_insert_with_merge.
package spim_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int WIDE_W      = (CNT_W > 7) ? CNT_W : 7;
	localparam int VAL_W       = 32;
	localparam int TOL_W       = 16;
	localparam int OUT_W       = 7;

	typedef struct packed {
		logic signed [VAL_W-1:0] param;
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] y;
		logic signed [VAL_W-1:0] z;
	} entry_t;

	typedef struct packed {
		logic load_new;
		logic load_left;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

endpackage

// ===== hw/rtl/sorted_point_insert_with_merge.sv =====
// Top level of the sorted point table with tolerance merge: a row of spim_cell
// slots, the spim_pick first-hit search and the stream handshakes. Uses spim_pkg.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: param, x, y, z; s_tuser: replace flag
//  m_*     | out | m_tvalid/m_tready  | m_tdata: position, entry count; m_tuser: flags
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: match tolerance
//
// The transfer cycle latches each item and registers every slot's compare flags;
// the update state picks the first hit and shifts the row. A held result in the
// output register stalls the update cycle until it is taken.
// Reset empties the table and sets the tolerance to one.
module sorted_point_insert_with_merge
	import spim_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // param_value, point_x, point_y, point_z
	input  logic [0:0]   s_tuser,   // replace_match
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [15:0]  m_tdata,   // position[6:0], entry_count[13:7], zeros
	output logic [1:0]   m_tuser,   // matched_existing, dropped_full
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data   // match_tolerance
);

	state_t                 state_q;
	state_t                 state_d;
	logic [TOL_W-1:0]       tol_q;
	entry_t                 item_q;
	logic                   replace_q;
	logic [CNT_W-1:0]       count_q;
	logic                   m_tvalid_q;
	logic [15:0]            m_tdata_q;
	logic [1:0]             m_tuser_q;

	logic                   s_fire;
	logic                   upd_go;
	entry_t                 in_entry;
	entry_t                 cell_entry [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_vec;
	logic [TABLE_DEPTH-1:0] ge_vec;
	logic [TABLE_DEPTH-1:0] le_vec;
	logic [TABLE_DEPTH-1:0] past_first;
	logic [TABLE_DEPTH-1:0] first;
	logic                   found;
	logic [IDX_W-1:0]       hit_idx;
	logic                   full;
	logic                   hit_match;
	logic                   do_insert;
	logic                   do_write;
	logic                   dropped;
	logic [CNT_W-1:0]       count_d;
	logic [WIDE_W-1:0]      pos_wide;
	logic [WIDE_W-1:0]      cnt_wide;

	assign cfg_ready = 1'b1;
	assign s_fire    = s_tvalid && s_tready;

	assign in_entry.param = $signed(s_tdata[31:0]);
	assign in_entry.x     = $signed(s_tdata[63:32]);
	assign in_entry.y     = $signed(s_tdata[95:64]);
	assign in_entry.z     = $signed(s_tdata[127:96]);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (upd_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		upd_go   = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_UPDATE: upd_go = !m_tvalid_q || m_tready;
			default: begin
				s_tready = 1'b0;
				upd_go   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tol_q      <= TOL_W'(1);
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			if (upd_go) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_q    <= in_entry;
			replace_q <= s_tuser[0];
		end
		if (upd_go) begin
			m_tdata_q <= {2'b00, cnt_wide[OUT_W-1:0], pos_wide[OUT_W-1:0]};
			m_tuser_q <= {dropped, hit_match};
		end
	end

	for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
		entry_t    left_entry;
		logic      left_valid;
		cell_ctl_t ctl;

		if (j == 0) begin : g_head
			assign left_entry = '0;
			assign left_valid = 1'b0;
		end else begin : g_link
			assign left_entry = cell_entry[j-1];
			assign left_valid = valid_vec[j-1];
		end

		assign ctl.load_new  = upd_go && first[j] && do_write;
		assign ctl.load_left = upd_go && past_first[j] && do_insert;

		spim_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmp_en     (s_fire),
			.new_param  (in_entry.param),
			.tol        (tol_q),
			.ctl        (ctl),
			.new_entry  (item_q),
			.left_entry (left_entry),
			.left_valid (left_valid),
			.entry      (cell_entry[j]),
			.valid      (valid_vec[j]),
			.ge         (ge_vec[j]),
			.le         (le_vec[j])
		);
	end

	spim_pick u_pick (
		.ge_vec     (ge_vec),
		.past_first (past_first),
		.first      (first),
		.found      (found),
		.hit_idx    (hit_idx)
	);

	always_comb begin
		full      = (count_q == CNT_W'(TABLE_DEPTH));
		hit_match = |(first & le_vec);
		do_insert = found && !hit_match && !full;
		do_write  = do_insert || (hit_match && replace_q);
		dropped   = !hit_match && full;
		count_d   = count_q + CNT_W'(do_insert);
		pos_wide  = dropped ? '0 : (WIDE_W'(hit_idx) + WIDE_W'(1));
		cnt_wide  = WIDE_W'(count_d);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// occupied slots stay packed at the low end and track the count
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(count_q))
		else $error("slot valid bits disagree with entry count");

	// no hit at all can only happen with every slot occupied
	a_miss_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && !found) |-> full)
		else $error("search missed with free slots");

	// a transfer in always leads into the update cycle
	a_accept_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (state_q == ST_UPDATE))
		else $error("accepted item did not reach update");

	// a new result appears only out of an update cycle
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_UPDATE))
		else $error("result raised without an update");

endmodule

// ===== hw/rtl/spim_cell.sv =====
// One slot of the sorted table: holds an entry, compares it with a new parameter
// and loads either the new entry or its left neighbour. Depends on spim_pkg.
module spim_cell
	import spim_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmp_en,
	input  logic signed [VAL_W-1:0] new_param,
	input  logic        [TOL_W-1:0] tol,
	input  cell_ctl_t               ctl,
	input  entry_t                  new_entry,
	input  entry_t                  left_entry,
	input  logic                    left_valid,
	output entry_t                  entry,
	output logic                    valid,
	output logic                    ge,
	output logic                    le
);

	entry_t             entry_q;
	logic               valid_q;
	logic               ge_q;
	logic               le_q;
	logic signed [VAL_W:0] diff;
	logic signed [VAL_W:0] tol_ext;
	logic               ge_d;
	logic               le_d;

	always_comb begin
		diff    = {entry_q.param[VAL_W-1], entry_q.param} - {new_param[VAL_W-1], new_param};
		tol_ext = $signed({{(VAL_W+1-TOL_W){1'b0}}, tol});
		// an empty slot always stops the search so that appends land at the end
		ge_d    = !valid_q || (diff >= -tol_ext);
		le_d    = valid_q && (diff <= tol_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load_new) begin
			valid_q <= 1'b1;
		end else if (ctl.load_left) begin
			valid_q <= left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_new) begin
			entry_q <= new_entry;
		end else if (ctl.load_left) begin
			entry_q <= left_entry;
		end
		if (cmp_en) begin
			ge_q <= ge_d;
			le_q <= le_d;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign ge    = ge_q;
	assign le    = le_q;

endmodule

// ===== hw/rtl/spim_pick.sv =====
// First-hit search over the row of compare flags: log-depth prefix OR,
// one-hot of the first hit and its binary index. Depends on spim_pkg.
module spim_pick
	import spim_pkg::*;
(
	input  logic [TABLE_DEPTH-1:0] ge_vec,
	output logic [TABLE_DEPTH-1:0] past_first,
	output logic [TABLE_DEPTH-1:0] first,
	output logic                   found,
	output logic [IDX_W-1:0]       hit_idx
);

	logic [TABLE_DEPTH-1:0] incl;

	always_comb begin
		incl = ge_vec;
		for (int s = 0; s < IDX_W; s++) begin
			incl = incl | (incl << (1 << s));
		end
		past_first = incl << 1;
		first      = ge_vec & ~past_first;
		found      = |ge_vec;
	end

	always_comb begin
		hit_idx = '0;
		for (int b = 0; b < IDX_W; b++) begin
			for (int j = 0; j < TABLE_DEPTH; j++) begin
				if (((j >> b) & 1) == 1) begin
					hit_idx[b] = hit_idx[b] | first[j];
				end
			end
		end
	end

endmodule
